// ===== rtl/spq_pkg.sv =====
// Shared constants and types for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH    = 16;
  localparam int TAG_BITS = 16;
  localparam int PRI_W    = 16;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int COUNT_W  = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef struct packed {
    logic signed [PRI_W-1:0] pri;
    logic [TAG_BITS-1:0]     tag;
  } entry_t;

  // Broadcast to every cell for the item being accepted.
  typedef struct packed {
    logic   ins;
    logic   del;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted row: holds an entry and shifts it left or right.
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       valid,
  input  logic       left_ge,
  input  entry_t     left_entry,
  input  entry_t     right_entry,
  output entry_t     entry,
  output logic       ge
);

  // The held entry stays ahead of the new one when its priority is not lower.
  assign ge = valid && (entry.pri >= ctrl.new_entry.pri);

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (!ge) begin
        if (left_ge) begin
          entry <= ctrl.new_entry;
        end else begin
          entry <= left_entry;
        end
      end
    end else if (ctrl.del) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== rtl/sorted_priority_queue_core.sv =====
// Sorted priority queue: a row of cells kept in priority order, head in cell 0.
// Each accepted item's result is registered in the output register.
// One item per cycle when s_tready is high; all cells compare and shift in the same cycle.
// The next item may be accepted while the output register is being emptied.
// Reset (synchronous, rst high) empties the queue and the output register at once;
// cell contents are left as they are and are never read before being written.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // priority_req[15:0], data_tag[31:16]
  input  logic        s_tuser,   // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // out_priority[15:0], out_tag[31:16], count[36:32], zeros
  output logic [2:0]  m_tuser    // got_entry, was_empty, overflow
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             accept;
  op_t              op;
  cell_ctrl_t       ctrl;
  entry_t           cell_entry [DEPTH];
  logic [DEPTH-1:0] cell_ge;
  logic [DEPTH-1:0] cell_valid;
  logic             full;
  logic             empty;

  logic [TAG_BITS+15:0]      tag_in_ext;
  logic [TAG_BITS+15:0]      tag_out_ext;
  logic [CNT_W+COUNT_W-1:0]  count_ext;

  logic                     got_entry;
  logic                     was_empty;
  logic                     overflow;
  logic signed [PRI_W-1:0]  out_priority;
  logic [15:0]              out_tag;
  logic [COUNT_W-1:0]       out_count;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);

  assign tag_in_ext          = {{TAG_BITS{1'b0}}, s_tdata[31:16]};
  assign ctrl.new_entry.pri  = s_tdata[15:0];
  assign ctrl.new_entry.tag  = tag_in_ext[TAG_BITS-1:0];
  assign ctrl.ins            = accept && (op == OP_INSERT) && !full;
  assign ctrl.del            = accept && (op == OP_DELETE) && !empty;

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.del) begin
      count_next = count - 1'b1;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_valid[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .valid      (cell_valid[i]),
        .left_ge    (1'b1),
        .left_entry (ctrl.new_entry),
        .right_entry(cell_entry[i+1]),
        .entry      (cell_entry[i]),
        .ge         (cell_ge[i])
      );
    end else if (i == DEPTH - 1) begin : g_tail
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .valid      (cell_valid[i]),
        .left_ge    (cell_ge[i-1]),
        .left_entry (cell_entry[i-1]),
        .right_entry(ctrl.new_entry),
        .entry      (cell_entry[i]),
        .ge         (cell_ge[i])
      );
    end else begin : g_mid
      spq_cell u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .valid      (cell_valid[i]),
        .left_ge    (cell_ge[i-1]),
        .left_entry (cell_entry[i-1]),
        .right_entry(cell_entry[i+1]),
        .entry      (cell_entry[i]),
        .ge         (cell_ge[i])
      );
    end
  end

  assign tag_out_ext = {16'b0, cell_entry[0].tag};
  assign count_ext   = {{COUNT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Result payload is captured when the item is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      got_entry    <= ctrl.del;
      was_empty    <= (op == OP_DELETE) && empty;
      overflow     <= (op == OP_INSERT) && full;
      out_priority <= ctrl.del ? cell_entry[0].pri : '0;
      out_tag      <= ctrl.del ? tag_out_ext[15:0] : '0;
      out_count    <= count_ext[COUNT_W-1:0];
    end
  end

  assign m_tdata = {3'b000, out_count, out_tag, out_priority};
  assign m_tuser = {overflow, was_empty, got_entry};

endmodule
